### design/assert_macros.svh
// assertion macros used by the checker in sse_checker.sv
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SSE_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, disabled during reset
`define SSE_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### design/sse_pkg.sv
// types and codes for the sorted set engine
// no dependencies
package sse_pkg;

  localparam int KEY_W = 32;
  localparam int OUT_W = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INS,
    ST_DEL,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t                     operation;
    logic signed [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic             success;
    logic             full_res;
    logic [OUT_W-1:0] position;
    logic [OUT_W-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic goes_after;
    logic equal;
  } cmp_res_t;

endpackage

### design/sse_cmp.sv
// shared key comparator: decides whether the key passes a stored entry
// depends on sse_pkg
module sse_cmp (
  input  logic signed [sse_pkg::KEY_W-1:0] key,
  input  logic signed [sse_pkg::KEY_W-1:0] entry,
  input  logic                             descending,
  output sse_pkg::cmp_res_t                res
);

  // signed order test, direction picked by the order bit
  always_comb begin
    res.equal      = (key == entry);
    res.goes_after = descending ? (key < entry) : (key > entry);
  end

endmodule

### design/sse_store.sv
// key store: one write port, one read port with registered read data
// depends on sse_pkg
module sse_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [sse_pkg::KEY_W-1:0]  wdata,
  input  logic [AW-1:0]              raddr,
  output logic [sse_pkg::KEY_W-1:0]  rdata
);

  logic [sse_pkg::KEY_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### design/sorted_set_engine_unit.sv
// sorted set engine top level: sequencer, key store and shared comparator
// depends on sse_pkg, sse_store, sse_cmp
//
//  port group      | dir | handshake          | content
//  req             | in  | req_valid/ready    | operation, key
//  rsp             | out | rsp_valid/ready    | success, full_res, position, entry_count
//  cfg_write_*     | in  | write enable only  | descending order bit
//
// scan: one stored entry per cycle through the single comparator
// shift: one entry moved per cycle on insert and on remove
// req_ready is high only between items; a stalled rsp holds the sequencer in DONE
// rst clears the count, order bit and handshake state; the store itself is not cleared
module sorted_set_engine_unit #(
  parameter int CAPACITY = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  sse_pkg::req_t   req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output sse_pkg::rsp_t   rsp,
  input  logic            cfg_write_enable,
  input  logic            cfg_write_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);
  localparam logic [CW-1:0] TWO_C = CW'(2);

  sse_pkg::state_t state, state_next;
  logic [CW-1:0]   pos, pos_next;
  logic [CW-1:0]   idx, idx_next;
  logic [CW-1:0]   count, count_next;
  sse_pkg::req_t   item, item_next;
  logic            descending;
  logic            res_success, res_success_next;
  logic            res_full, res_full_next;
  logic            load_rsp;

  logic [CW-1:0]             raddr_w;
  logic [CW-1:0]             waddr_w;
  logic                      we;
  logic [sse_pkg::KEY_W-1:0] wdata;
  logic [sse_pkg::KEY_W-1:0] rdata;
  sse_pkg::cmp_res_t         cmp;
  logic                      scan_end;
  logic                      present;

  sse_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr_w[AW-1:0]),
    .wdata (wdata),
    .raddr (raddr_w[AW-1:0]),
    .rdata (rdata)
  );

  sse_cmp u_cmp (
    .key        (item.key),
    .entry      (rdata),
    .descending (descending),
    .res        (cmp)
  );

  // scan stop and hit detection
  assign scan_end = (pos == count) || !cmp.goes_after;
  assign present  = (pos != count) && cmp.equal;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sse_pkg::ST_IDLE;
      count      <= '0;
      descending <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_write_enable) begin
        descending <= cfg_write_data;
      end
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // working registers and result beat
  always_ff @(posedge clk) begin
    pos         <= pos_next;
    idx         <= idx_next;
    item        <= item_next;
    res_success <= res_success_next;
    res_full    <= res_full_next;
    if (load_rsp) begin
      rsp.success     <= res_success;
      rsp.full_res    <= res_full;
      rsp.position    <= sse_pkg::OUT_W'(pos);
      rsp.entry_count <= sse_pkg::OUT_W'(count);
    end
  end

  // sequencer
  always_comb begin
    state_next       = state;
    pos_next         = pos;
    idx_next         = idx;
    count_next       = count;
    item_next        = item;
    res_success_next = res_success;
    res_full_next    = res_full;
    req_ready        = 1'b0;
    load_rsp         = 1'b0;
    raddr_w          = '0;
    waddr_w          = idx;
    we               = 1'b0;
    wdata            = rdata;
    unique case (state)
      sse_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          item_next        = req;
          pos_next         = '0;
          res_success_next = 1'b0;
          res_full_next    = 1'b0;
          state_next       = sse_pkg::ST_SCAN;
        end
      end
      sse_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_next = sse_pkg::ST_DONE;
          case (item.operation)
            sse_pkg::OP_INSERT: begin
              if (!present && (count < CAP_C)) begin
                res_success_next = 1'b1;
                idx_next         = count;
                raddr_w          = count - ONE_C;
                state_next       = sse_pkg::ST_INS;
              end else begin
                res_full_next = !present;
              end
            end
            sse_pkg::OP_REMOVE: begin
              if (present) begin
                res_success_next = 1'b1;
                idx_next         = pos;
                raddr_w          = pos + ONE_C;
                state_next       = sse_pkg::ST_DEL;
              end
            end
            sse_pkg::OP_LOOKUP: begin
              res_success_next = present;
            end
            default: begin
              res_success_next = 1'b0;
            end
          endcase
        end else begin
          pos_next = pos + ONE_C;
          raddr_w  = pos + ONE_C;
        end
      end
      sse_pkg::ST_INS: begin
        we = 1'b1;
        if (idx == pos) begin
          waddr_w    = pos;
          wdata      = item.key;
          count_next = count + ONE_C;
          state_next = sse_pkg::ST_DONE;
        end else begin
          idx_next = idx - ONE_C;
          raddr_w  = idx - TWO_C;
        end
      end
      sse_pkg::ST_DEL: begin
        if ((idx + ONE_C) == count) begin
          count_next = count - ONE_C;
          state_next = sse_pkg::ST_DONE;
        end else begin
          we       = 1'b1;
          idx_next = idx + ONE_C;
          raddr_w  = idx + TWO_C;
        end
      end
      sse_pkg::ST_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          load_rsp   = 1'b1;
          state_next = sse_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sse_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### design/sse_checker.sv
// port-level checker for the sorted set engine, bound to the top level
// depends on sse_pkg and assert_macros.svh
`include "assert_macros.svh"

module sse_checker #(
  parameter int CAPACITY = 16
) (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input sse_pkg::rsp_t rsp
);

  // a stalled result beat holds its payload
  `SSE_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

  // the engine is not ready in the cycle after taking a beat
  `SSE_ASSERT_NXT(a_busy_after_req, clk, rst, req_valid && req_ready, !req_ready)

  // a refused insert never reports success
  `SSE_ASSERT_IMP(a_full_not_ok, clk, rst, rsp_valid && rsp.full_res, !rsp.success)

  // a refused insert only happens with the store at capacity
  `SSE_ASSERT_IMP(a_full_count, clk, rst, rsp_valid && rsp.full_res, rsp.entry_count == sse_pkg::OUT_W'(CAPACITY))

endmodule

bind sorted_set_engine_unit sse_checker #(.CAPACITY(CAPACITY)) u_sse_checker (.*);

### verif/tb_sorted_set_engine_unit.sv
// testbench for sorted_set_engine_unit: random and directed insert, remove and lookup beats
// with a scoreboard built from its own copy of the sorted key store
// depends on sse_pkg and the sorted_set_engine_unit rtl
module tb_sorted_set_engine_unit;

  localparam int          CAPACITY    = 16;
  localparam int          PERIOD      = 8;
  localparam int          MAX_GAP     = 18;
  localparam int          SETTLE      = 2 * CAPACITY + 8;
  localparam int          LONG_STALL  = 300;
  localparam int          POOL_N      = 24;
  localparam int          N_PHASES    = 10;
  localparam int          PHASE_ITEMS = 165;
  localparam longint      TIMEOUT_TU  = 6000000;
  localparam logic [1:0]  OP_RESERVED = 2'd3;
  localparam logic [sse_pkg::KEY_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic [sse_pkg::KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;

  logic           clk              = 1'b0;
  logic           rst              = 1'b1;
  logic           req_valid        = 1'b0;
  logic           req_ready;
  sse_pkg::req_t  req              = '0;
  logic           rsp_valid;
  logic           rsp_ready        = 1'b0;
  sse_pkg::rsp_t  rsp;
  logic           cfg_write_enable = 1'b0;
  logic           cfg_write_data   = 1'b0;

  // shadow of the key store and order bit
  logic signed [sse_pkg::KEY_W-1:0] held_keys [CAPACITY];
  int                               held_count = 0;
  bit                               order_desc = 1'b0;

  sse_pkg::req_t                    req_backlog [$];
  sse_pkg::rsp_t                    owed_rsp [$];
  logic signed [sse_pkg::KEY_W-1:0] key_pool [POOL_N];

  int  errs       = 0;
  int  tx_gap     = 0;
  int  rx_gap     = 0;
  bit  tx_idle_en = 1'b0;
  bit  rx_idle_en = 1'b0;
  bit  stall_req  = 1'b0;
  logic rx_blocked = 1'b0;

  sorted_set_engine_unit #(.CAPACITY(CAPACITY)) dut (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_ready        (req_ready),
    .req              (req),
    .rsp_valid        (rsp_valid),
    .rsp_ready        (rsp_ready),
    .rsp              (rsp),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data)
  );

  always #(PERIOD / 2) clk = ~clk;

  // apply one operation to the shadow store and return the reply it should give
  function automatic sse_pkg::rsp_t set_apply(sse_pkg::req_t r);
    sse_pkg::rsp_t                    res;
    int                               pos;
    int                               i;
    bit                               hit;
    logic signed [sse_pkg::KEY_W-1:0] k;
    k   = r.key;
    pos = 0;
    res = '0;
    // scan past entries the key must follow
    while (pos < held_count &&
           (order_desc ? (k < held_keys[pos]) : (k > held_keys[pos])))
      pos++;
    hit = (pos < held_count) && (held_keys[pos] == k);
    case (r.operation)
      sse_pkg::OP_INSERT: begin
        if (!hit) begin
          if (held_count >= CAPACITY) begin
            res.full_res = 1'b1;
          end else begin
            for (i = held_count; i > pos; i--)
              held_keys[i] = held_keys[i - 1];
            held_keys[pos] = k;
            held_count++;
            res.success = 1'b1;
          end
        end
      end
      sse_pkg::OP_REMOVE: begin
        if (hit) begin
          for (i = pos; i + 1 < held_count; i++)
            held_keys[i] = held_keys[i + 1];
          held_count--;
          res.success = 1'b1;
        end
      end
      sse_pkg::OP_LOOKUP: res.success = hit;
      default: ;
    endcase
    res.position    = sse_pkg::OUT_W'(pos);
    res.entry_count = sse_pkg::OUT_W'(held_count);
    return res;
  endfunction

  // request driver: predicts on every accepted beat, then idles or offers the next one
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (req_valid && req_ready) begin
        owed_rsp.push_back(set_apply(req));
        tx_gap = tx_idle_en ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (!req_valid || req_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          req_valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          req       <= req_backlog.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response monitor and ready generator
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (owed_rsp.size() == 0) begin
          errs++;
          $display("%0t: unexpected response beat, expected none, got %p", $time, rsp);
        end else begin
          if (rsp !== owed_rsp[0]) begin
            errs++;
            $display("%0t: response mismatch, expected %p, got %p",
                     $time, owed_rsp[0], rsp);
          end
          void'(owed_rsp.pop_front());
        end
        rx_gap = rx_idle_en ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (rx_gap > 0) begin
        rx_gap--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= !rx_blocked;
      end
    end
  end

  // one long receiver hold, counted here, so the engine backs up into the request side
  initial begin
    wait (stall_req);
    @(posedge clk);
    rx_blocked <= 1'b1;
    repeat (LONG_STALL) @(posedge clk);
    rx_blocked <= 1'b0;
  end

  initial begin
    #(TIMEOUT_TU);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic queue_beat(logic [1:0] op, logic signed [sse_pkg::KEY_W-1:0] k);
    sse_pkg::req_t item;
    item.operation = sse_pkg::op_t'(op);
    item.key       = k;
    req_backlog.push_back(item);
  endtask

  // order register write, only while the engine is idle
  task automatic write_order(bit desc);
    @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_write_data   <= desc;
    @(posedge clk);
    order_desc = desc;
    cfg_write_enable <= 1'b0;
  endtask

  // sender pause until every reply is in, then let the sequencer settle
  task automatic wait_quiet();
    do @(negedge clk);
    while (req_backlog.size() != 0 || req_valid || owed_rsp.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [sse_pkg::KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40 && held_count > 0)
      return held_keys[$urandom_range(0, held_count - 1)];
    if (r < 85)
      return key_pool[$urandom_range(0, POOL_N - 1)];
    return $signed($urandom);
  endfunction

  // random beats, mostly hitting keys in play, fed a couple at a time
  task automatic run_phase(int ins_pct, int rem_pct);
    int unsigned r;
    logic [1:0]  op;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      while (req_backlog.size() >= 2) @(negedge clk);
      r = $urandom_range(0, 99);
      if (r < ins_pct)                   op = sse_pkg::OP_INSERT;
      else if (r < ins_pct + rem_pct)    op = sse_pkg::OP_REMOVE;
      else if (r < 96)                   op = sse_pkg::OP_LOOKUP;
      else                               op = OP_RESERVED;
      queue_beat(op, pick_key());
    end
  endtask

  initial begin
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = 0;
    key_pool[3] = -1;
    key_pool[4] = 1;
    for (int i = 5; i < POOL_N; i++)
      key_pool[i] = $signed($urandom);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    write_order(1'b0);

    // directed: empty store, extremes, duplicates, absent keys, reserved code
    queue_beat(sse_pkg::OP_LOOKUP, 0);
    queue_beat(sse_pkg::OP_REMOVE, 7);
    queue_beat(OP_RESERVED, 0);
    queue_beat(sse_pkg::OP_INSERT, KEY_MAX);
    queue_beat(sse_pkg::OP_INSERT, KEY_MIN);
    queue_beat(sse_pkg::OP_INSERT, 0);
    queue_beat(sse_pkg::OP_INSERT, -1);
    queue_beat(sse_pkg::OP_INSERT, 1);
    queue_beat(sse_pkg::OP_INSERT, 0);
    queue_beat(sse_pkg::OP_LOOKUP, KEY_MIN);
    queue_beat(sse_pkg::OP_LOOKUP, KEY_MAX);
    queue_beat(sse_pkg::OP_LOOKUP, 2);
    queue_beat(sse_pkg::OP_REMOVE, 5);
    queue_beat(OP_RESERVED, 1);
    queue_beat(sse_pkg::OP_REMOVE, KEY_MAX);
    queue_beat(sse_pkg::OP_REMOVE, KEY_MIN);
    queue_beat(sse_pkg::OP_LOOKUP, -1);
    wait_quiet();

    // random phases; the order bit flips with keys still held
    for (int p = 0; p < N_PHASES; p++) begin
      for (int i = 5 + (p % 2); i < POOL_N; i += 2)
        key_pool[i] = $signed($urandom);
      write_order(p == 0 ? 1'b1 : p == N_PHASES - 1 ? 1'b0 : 1'($urandom_range(0, 1)));
      tx_idle_en = (p % 3) != 0;
      rx_idle_en = (p % 4) != 1;
      if (p == 3)
        stall_req = 1'b1;
      if (p % 3 == 2)
        run_phase(20, 50);
      else
        run_phase(45, 25);
      wait_quiet();
    end

    if (errs == 0 && owed_rsp.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
